// ===== rtl/mcmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcmc_pkg: shared types and constants for the matrix chain cost block
// Transfer payloads, controller command/status structs and error codes.
// ----------------------------------------------------------------------------
package mcmc_pkg;

  localparam int unsigned DIM_W      = 16;
  localparam int unsigned COST_OUT_W = 52;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned ERR_W      = 2;

  localparam logic [COST_OUT_W-1:0] COST_MAX = '1;

  localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_TOO_FEW  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_TOO_MANY = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0] dimension;
    logic             last_dimension;
  } in_item_t;

  typedef struct packed {
    logic [COST_OUT_W-1:0] min_cost;
    logic [COUNT_W-1:0]    matrix_count;
    logic [ERR_W-1:0]      error_code;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic             dim_wr;       // store incoming dimension
    logic             setup_rd;     // read b[lo] and b[hi+1] for a new cell
    logic             init_best;    // reset running minimum
    logic             split_issue;  // issue one split evaluation
    logic             cost_wr;      // write cell result to the cost table
    logic             load_out;     // load the output register
    logic             res_zero;     // result cost forced to zero
    logic [ERR_W-1:0] res_err;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage : mcmc_pkg
`default_nettype wire

// ===== rtl/mcmc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcmc_datapath: dimension store, cost table and split evaluation pipeline
// Three-stage split pipeline: table/dimension read, product and left+right
// sum, then final add and running minimum. Holds the output register.
// ----------------------------------------------------------------------------
module mcmc_datapath
  import mcmc_pkg::*;
#(
  parameter int unsigned MAX_MATRICES = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire ctl_cmd_t                               cmd,
  input  wire logic [$clog2(MAX_MATRICES+1)-1:0]      dim_waddr,
  input  wire logic [((MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1)-1:0] lo,
  input  wire logic [((MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1)-1:0] hi,
  input  wire logic [((MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1)-1:0] split,
  input  wire logic [$clog2(MAX_MATRICES+1)-1:0]      res_count,
  input  wire logic [DIM_W-1:0]                       dimension,
  input  wire logic                                   out_stall,
  output dp_sts_t                                     sts,
  output logic                                        out_valid,
  output out_item_t                                   out_data
);

  localparam int unsigned IW    = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
  localparam int unsigned DAW   = $clog2(MAX_MATRICES + 1);
  localparam int unsigned DDEP  = MAX_MATRICES + 1;
  localparam int unsigned CDEP  = MAX_MATRICES * MAX_MATRICES;
  localparam int unsigned CAW   = (CDEP > 1) ? $clog2(CDEP) : 1;
  localparam int unsigned PW    = 3 * DIM_W;
  localparam int unsigned CW    = PW + $clog2(MAX_MATRICES);
  localparam int unsigned XW    = (CW > COST_OUT_W) ? CW : COST_OUT_W;

  logic [DIM_W-1:0]   dim_mem [DDEP];
  logic [CW-1:0]      cost_mem [CDEP];

  logic [DAW-1:0]     dim_addr_a, dim_addr_b;
  logic [CAW-1:0]     left_addr, right_addr, wr_addr;
  logic [DIM_W-1:0]   rd_a_r, rd_b_r;
  logic [CW-1:0]      left_q_r, right_q_r;

  logic               setup_d_r;
  logic               v1_r, v2_r;
  logic               lz_r, rz_r;
  logic [2*DIM_W-1:0] outer_r;
  logic [PW-1:0]      prod_r;
  logic [CW-1:0]      lr_r;
  logic [CW-1:0]      best_r, best_nxt;
  logic [CW-1:0]      sum_c;
  logic [XW-1:0]      best_x;
  logic [COST_OUT_W-1:0] cost_sat;

  logic               out_valid_r;
  out_item_t          out_data_r;

  assign dim_addr_a = cmd.setup_rd ? DAW'(lo) : (DAW'(split) + 1'b1);
  assign dim_addr_b = DAW'(hi) + 1'b1;

  assign left_addr  = CAW'(int'(lo) * MAX_MATRICES + int'(split));
  assign right_addr = CAW'((int'(split) + 1) * MAX_MATRICES + int'(hi));
  assign wr_addr    = CAW'(int'(lo) * MAX_MATRICES + int'(hi));

  // dimension store
  always_ff @(posedge clk) begin
    if (cmd.dim_wr) begin
      dim_mem[dim_waddr] <= dimension;
    end
    rd_a_r <= dim_mem[dim_addr_a];
    rd_b_r <= dim_mem[dim_addr_b];
  end

  // cost table
  always_ff @(posedge clk) begin
    if (cmd.cost_wr) begin
      cost_mem[wr_addr] <= best_r;
    end
    left_q_r  <= cost_mem[left_addr];
    right_q_r <= cost_mem[right_addr];
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_d_r <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
    end else begin
      setup_d_r <= cmd.setup_rd;
      v1_r      <= cmd.split_issue;
      v2_r      <= v1_r;
    end
  end

  // payload stages; diagonal entries read as zero
  always_ff @(posedge clk) begin
    lz_r <= (split == lo);
    rz_r <= ((IW'(split) + 1'b1) == hi);
    if (setup_d_r) begin
      outer_r <= rd_a_r * rd_b_r;
    end
    prod_r <= outer_r * rd_a_r;
    lr_r   <= (lz_r ? '0 : left_q_r) + (rz_r ? '0 : right_q_r);
  end

  assign sum_c = lr_r + CW'(prod_r);

  always_comb begin
    best_nxt = best_r;
    if (cmd.init_best) begin
      best_nxt = '1;
    end else if (v2_r && (sum_c < best_r)) begin
      best_nxt = sum_c;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
  end

  assign best_x   = XW'(best_r);
  assign cost_sat = (best_x > XW'(COST_MAX)) ? COST_MAX : best_x[COST_OUT_W-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.min_cost     <= cmd.res_zero ? '0 : cost_sat;
      out_data_r.matrix_count <= COUNT_W'(res_count);
      out_data_r.error_code   <= cmd.res_err;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule : mcmc_datapath
`default_nettype wire

// ===== rtl/mcmc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcmc_ctrl: sequencer for dimension loading and the diagonal table fill
// Counts dimensions, classifies the chain and walks span, lo and split.
// ----------------------------------------------------------------------------
module mcmc_ctrl
  import mcmc_pkg::*;
#(
  parameter int unsigned MAX_MATRICES = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  input  wire logic                                   last_dimension,
  output logic                                        in_stall,
  input  wire dp_sts_t                                sts,
  output ctl_cmd_t                                    cmd,
  output logic [$clog2(MAX_MATRICES+1)-1:0]           dim_waddr,
  output logic [((MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1)-1:0] lo,
  output logic [((MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1)-1:0] hi,
  output logic [((MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1)-1:0] split,
  output logic [$clog2(MAX_MATRICES+1)-1:0]           res_count
);

  localparam int unsigned IW   = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
  localparam int unsigned DAW  = $clog2(MAX_MATRICES + 1);
  localparam int unsigned CNTW = $clog2(MAX_MATRICES + 2);
  localparam int unsigned MW   = $clog2(MAX_MATRICES + 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SETUP  = 7'b0000010,
    ST_SPLIT  = 7'b0000100,
    ST_DRAIN1 = 7'b0001000,
    ST_DRAIN2 = 7'b0010000,
    ST_WRITE  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt, new_cnt;
  logic             ovf_r, ovf_nxt, ovf_any, room;
  logic [IW-1:0]    lo_r, lo_nxt, hi_r, hi_nxt, span_r, span_nxt;
  logic [IW-1:0]    split_r, split_nxt, mlast_r, mlast_nxt;
  logic [MW-1:0]    mc_r, mc_nxt;
  logic [ERR_W-1:0] err_r, err_nxt;
  logic             zero_r, zero_nxt;

  assign room    = (cnt_r < CNTW'(MAX_MATRICES + 1));
  assign new_cnt = room ? (cnt_r + 1'b1) : cnt_r;
  assign ovf_any = ovf_r || !room;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    span_nxt  = span_r;
    split_nxt = split_r;
    mlast_nxt = mlast_r;
    mc_nxt    = mc_r;
    err_nxt   = err_r;
    zero_nxt  = zero_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (room) begin
            cmd.dim_wr = 1'b1;
            cnt_nxt    = new_cnt;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (last_dimension) begin
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
            if (ovf_any) begin
              err_nxt   = ERR_TOO_MANY;
              zero_nxt  = 1'b1;
              mc_nxt    = '0;
              state_nxt = ST_FINISH;
            end else if (new_cnt < CNTW'(2)) begin
              err_nxt   = ERR_TOO_FEW;
              zero_nxt  = 1'b1;
              mc_nxt    = '0;
              state_nxt = ST_FINISH;
            end else if (new_cnt == CNTW'(2)) begin
              err_nxt   = ERR_OK;
              zero_nxt  = 1'b1;
              mc_nxt    = MW'(1);
              state_nxt = ST_FINISH;
            end else begin
              err_nxt   = ERR_OK;
              zero_nxt  = 1'b0;
              mc_nxt    = MW'(new_cnt - 1'b1);
              mlast_nxt = IW'(new_cnt - CNTW'(2));
              lo_nxt    = '0;
              hi_nxt    = IW'(1);
              span_nxt  = IW'(1);
              state_nxt = ST_SETUP;
            end
          end
        end
      end
      ST_SETUP: begin
        cmd.setup_rd  = 1'b1;
        cmd.init_best = 1'b1;
        split_nxt     = lo_r;
        state_nxt     = ST_SPLIT;
      end
      ST_SPLIT: begin
        cmd.split_issue = 1'b1;
        if (split_r == (hi_r - 1'b1)) begin
          state_nxt = ST_DRAIN1;
        end else begin
          split_nxt = split_r + 1'b1;
        end
      end
      ST_DRAIN1: begin
        state_nxt = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.cost_wr = 1'b1;
        if (span_r == mlast_r) begin
          state_nxt = ST_FINISH;
        end else if (hi_r == mlast_r) begin
          // next diagonal
          span_nxt  = span_r + 1'b1;
          lo_nxt    = '0;
          hi_nxt    = span_r + 1'b1;
          state_nxt = ST_SETUP;
        end else begin
          lo_nxt    = lo_r + 1'b1;
          hi_nxt    = hi_r + 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_FINISH: begin
        cmd.res_err  = err_r;
        cmd.res_zero = zero_r;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    span_r  <= span_nxt;
    split_r <= split_nxt;
    mlast_r <= mlast_nxt;
    mc_r    <= mc_nxt;
    err_r   <= err_nxt;
    zero_r  <= zero_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign dim_waddr = cnt_r[DAW-1:0];
  assign lo        = lo_r;
  assign hi        = hi_r;
  assign split     = split_r;
  assign res_count = mc_r;

endmodule : mcmc_ctrl
`default_nettype wire

// ===== rtl/matrix_chain_min_cost.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_chain_min_cost: minimum scalar multiplication count of a matrix chain
// Takes dimensions b0..bn one per transfer, the final one flagged, and returns
// the optimal multiplication cost of the chain of n matrices.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall, one dimension per transfer, accepted one
// per cycle while no chain is being evaluated. Dimensions beyond
// MAX_MATRICES+1 are dropped and flag error 2; a flag on the first dimension
// gives error 1. Either error, and a single matrix, report without compute.
// After the flagged transfer the input stalls while the cost table is filled
// diagonal by diagonal. Each cell takes a dimension read, one split per cycle
// through a three-stage read/multiply/minimum pipeline, and the drain and
// table write; the result is then loaded into the output register. The fill
// runs through the single shared split pipeline.
// Output channel: out_valid/out_stall, held in an output register. While it
// waits on a stalled receiver, dimensions of the next chain are still taken;
// a finished chain waits in its last state until the register frees.
// Reset (rst_n low, synchronous) empties the chain and the output register.
// ----------------------------------------------------------------------------
module matrix_chain_min_cost
  import mcmc_pkg::*;
#(
  parameter int unsigned MAX_MATRICES = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int unsigned IW  = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
  localparam int unsigned DAW = $clog2(MAX_MATRICES + 1);
  localparam int unsigned MW  = $clog2(MAX_MATRICES + 1);

  ctl_cmd_t       cmd;
  dp_sts_t        sts;
  logic [DAW-1:0] dim_waddr;
  logic [IW-1:0]  lo, hi, split;
  logic [MW-1:0]  res_count;

  // sequencer: dimension count, chain checks, span/lo/split walk
  mcmc_ctrl #(
    .MAX_MATRICES (MAX_MATRICES)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .last_dimension (in_data.last_dimension),
    .in_stall       (in_stall),
    .sts            (sts),
    .cmd            (cmd),
    .dim_waddr      (dim_waddr),
    .lo             (lo),
    .hi             (hi),
    .split          (split),
    .res_count      (res_count)
  );

  // stores, split pipeline and output register
  mcmc_datapath #(
    .MAX_MATRICES (MAX_MATRICES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .dim_waddr (dim_waddr),
    .lo        (lo),
    .hi        (hi),
    .split     (split),
    .res_count (res_count),
    .dimension (in_data.dimension),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule : matrix_chain_min_cost
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for matrix_chain_min_cost
// Streams chains of dimensions into the block and checks every returned cost,
// matrix count and error code against a local recurrence, or against a fixed
// value for some directed chains. The sender works in bursts and the receiver
// applies back-pressure in changing patterns.
module tb;
  import mcmc_pkg::*;

  localparam int unsigned MAX_MATRICES = 16;
  localparam int unsigned DIM_SLOTS    = MAX_MATRICES + 1;
  localparam int unsigned RANDOM_ITEMS = 1780;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // covers the longest fill, at 16 matrices
  localparam int unsigned DRAIN_CYCLES = 1400;
  localparam int unsigned N_DIRECTED   = 25;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  always #5 clk = ~clk;

  matrix_chain_min_cost #(
    .MAX_MATRICES(MAX_MATRICES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // -------------------------------------------------------------------------
  // Chain predictor: own copy of the dimension list and its status
  // -------------------------------------------------------------------------
  logic [DIM_W-1:0] chain_dims [DIM_SLOTS];
  int unsigned      dims_held = 0;
  bit               dims_dropped = 1'b0;
  out_item_t        pending_results [$];
  int unsigned      mismatches = 0;

  // Returns 1 when the dimension closes a chain, with the result in res.
  function automatic bit take_dimension(input in_item_t item, output out_item_t res);
    logic [63:0] span_cost [MAX_MATRICES][MAX_MATRICES];
    logic [63:0] best;
    logic [63:0] trial;
    int          n;
    int          hi;
    res = '0;
    if (dims_held < DIM_SLOTS) begin
      chain_dims[dims_held] = item.dimension;
      dims_held++;
    end else begin
      dims_dropped = 1'b1;
    end
    if (!item.last_dimension) return 1'b0;

    if (dims_dropped) begin
      res.error_code = ERR_TOO_MANY;
    end else if (dims_held < 2) begin
      res.error_code = ERR_TOO_FEW;
    end else begin
      n = dims_held - 1;
      for (int lo = 0; lo < n; lo++) span_cost[lo][lo] = '0;
      for (int span = 1; span < n; span++) begin
        for (int lo = 0; lo + span < n; lo++) begin
          hi   = lo + span;
          best = '1;
          for (int split = lo; split < hi; split++) begin
            trial = span_cost[lo][split] + span_cost[split+1][hi]
                  + 64'(chain_dims[lo]) * 64'(chain_dims[split+1]) * 64'(chain_dims[hi+1]);
            if (trial < best) best = trial;
          end
          span_cost[lo][hi] = best;
        end
      end
      best = span_cost[0][n-1];
      res.min_cost     = (best > 64'(COST_MAX)) ? COST_MAX : best[COST_OUT_W-1:0];
      res.matrix_count = COUNT_W'(n);
      res.error_code   = ERR_OK;
    end
    dims_held    = 0;
    dims_dropped = 1'b0;
    return 1'b1;
  endfunction

  function automatic void note_mismatch(input string what, input out_item_t want,
                                        input out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected cost %0d count %0d err %0d, got cost %0d count %0d err %0d",
               what, want.min_cost, want.matrix_count, want.error_code,
               got.min_cost, got.matrix_count, got.error_code);
  endfunction

  // -------------------------------------------------------------------------
  // Result checker
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch("no result due", '0, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.min_cost !== want.min_cost ||
            out_data.matrix_count !== want.matrix_count ||
            out_data.error_code !== want.error_code)
          note_mismatch("field", want, out_data);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver back-pressure: modes from free-flowing to heavy, each held for a
  // random run of cycles
  // -------------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned stall_run = 0;

  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run  <= $urandom_range(20, 200);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  // -------------------------------------------------------------------------
  // Watchdog
  // -------------------------------------------------------------------------
  int unsigned cycle_count = 0;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Sender
  // -------------------------------------------------------------------------
  int unsigned burst_left = 0;

  // Called at a rising edge; returns at the edge of the transfer or after the
  // gap that follows it.
  task automatic send_transfer(input in_item_t item, input bit fixed, input out_item_t want);
    out_item_t predicted;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (take_dimension(item, predicted))
      pending_results.push_back(fixed ? want : predicted);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  typedef struct {
    logic [DIM_W-1:0] dimension;
    bit               last;
    bit               fixed;
    out_item_t        want;
  } stim_row_t;

  stim_row_t directed [N_DIRECTED];

  initial begin
    directed = '{
      // flag on the first dimension
      '{16'd7,     1'b1, 1'b1, '{52'd0, 5'd0, ERR_TOO_FEW}},
      // single matrix at full dimensions
      '{16'hFFFF,  1'b0, 1'b0, '0},
      '{16'hFFFF,  1'b1, 1'b1, '{52'd0, 5'd1, ERR_OK}},
      // zero dimension used as is
      '{16'd0,     1'b0, 1'b0, '0},
      '{16'hFFFF,  1'b0, 1'b0, '0},
      '{16'd1,     1'b0, 1'b0, '0},
      '{16'hFFFF,  1'b1, 1'b0, '0},
      // one dimension too many: dropped, error on the flag
      '{16'hFFFF,  1'b0, 1'b0, '0},
      '{16'd1,     1'b0, 1'b0, '0},
      '{16'hFFFF,  1'b0, 1'b0, '0},
      '{16'd1,     1'b0, 1'b0, '0},
      '{16'hFFFF,  1'b0, 1'b0, '0},
      '{16'd1,     1'b0, 1'b0, '0},
      '{16'hFFFF,  1'b0, 1'b0, '0},
      '{16'd1,     1'b0, 1'b0, '0},
      '{16'hFFFF,  1'b0, 1'b0, '0},
      '{16'd1,     1'b0, 1'b0, '0},
      '{16'hFFFF,  1'b0, 1'b0, '0},
      '{16'd1,     1'b0, 1'b0, '0},
      '{16'hFFFF,  1'b0, 1'b0, '0},
      '{16'd1,     1'b0, 1'b0, '0},
      '{16'hFFFF,  1'b0, 1'b0, '0},
      '{16'd1,     1'b0, 1'b0, '0},
      '{16'hFFFF,  1'b0, 1'b0, '0},
      '{16'h8000,  1'b1, 1'b1, '{52'd0, 5'd0, ERR_TOO_MANY}}
    };
  end

  initial begin
    in_item_t    item;
    int unsigned items_sent;
    int unsigned chain_no;
    int unsigned kind;
    int unsigned len;
    int unsigned style;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[r]) begin
      item.dimension      = directed[r].dimension;
      item.last_dimension = directed[r].last;
      send_transfer(item, directed[r].fixed, directed[r].want);
    end

    // Mostly well-formed chains, short ones favoured; a few flags on a lone
    // dimension and a few over-long chains. The first chain is full length
    // at the largest dimension, the costliest case.
    items_sent = 0;
    chain_no   = 0;
    while (items_sent < RANDOM_ITEMS) begin
      kind  = $urandom_range(0, 19);
      style = $urandom_range(0, 7);
      if (chain_no == 0) begin
        len   = DIM_SLOTS;
        style = 0;
      end else if (kind == 0) begin
        len = 1;
      end else if (kind == 1) begin
        len = $urandom_range(DIM_SLOTS + 1, DIM_SLOTS + 24);
      end else if (kind < 5) begin
        len = $urandom_range(2, DIM_SLOTS);
      end else begin
        len = $urandom_range(2, 6);
      end
      for (int i = 0; i < len; i++) begin
        case (style)
          0:       item.dimension = '1;
          1:       item.dimension = DIM_W'($urandom_range(0, 3));
          2:       item.dimension = DIM_W'($urandom);
          3:       item.dimension = ($urandom_range(0, 1) != 0) ? '1 : DIM_W'($urandom_range(0, 1));
          default: item.dimension = DIM_W'($urandom_range(1, 64));
        endcase
        item.last_dimension = (i == len - 1);
        send_transfer(item, 1'b0, '0);
        items_sent++;
      end
      chain_no++;
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    // room for a stray result from a late fill
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
